FILE: rtl/shbh_pkg.sv
// Shared constants and opcodes for the string hash bucket histogram.
package shbh_pkg;

   localparam int HASH_BITS       = 32;
   localparam int HASH_MULT       = 31;
   localparam int BUCKET_BITS     = 6;
   localparam int COST_BITS       = 53;
   localparam int BUCKETS_DEF     = 20;
   localparam int COUNT_BITS_DEF  = 24;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;
   localparam logic [1:0] OP_REPORT = 2'd3;

endpackage

FILE: rtl/shbh_mod_unit.sv
// Reduction of a 32-bit hash modulo the bucket count by reciprocal multiplication.
module shbh_mod_unit
   import shbh_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF,
   localparam int AW = $clog2(BUCKETS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [HASH_BITS-1:0] key_hash,
   output logic                 done,
   output logic [AW-1:0]        rem
);

   // q = floor(h * RECIP / 2^SH) is exact for every 32-bit h with RECIP = ceil(2^SH / BUCKETS)
   localparam int SH = HASH_BITS + AW;
   localparam int RW = HASH_BITS + 1;
   localparam int PW = HASH_BITS + RW;
   localparam logic [63:0]   RECIP_WIDE =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [RW-1:0] RECIP  = RECIP_WIDE[RW-1:0];
   localparam logic [AW-1:0] DIV_LO = AW'(BUCKETS);

   logic [HASH_BITS-1:0] hash_ff;
   logic [AW-1:0]        quot_lo_ff, quot_lo_in;
   logic [AW-1:0]        rem_ff, rem_in;
   logic [PW-1:0]        prod;
   logic [2*AW-1:0]      back;
   logic                 stage1_ff;
   logic                 stage2_ff;
   logic                 done_ff;

   assign prod       = PW'(hash_ff) * PW'(RECIP);
   assign quot_lo_in = prod[SH +: AW];

   // remainder is below BUCKETS, so only its low AW bits need computing
   assign back   = {{AW{1'b0}}, quot_lo_ff} * {{AW{1'b0}}, DIV_LO};
   assign rem_in = hash_ff[AW-1:0] - back[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hash_ff <= key_hash;
      end
      if (stage1_ff) begin
         quot_lo_ff <= quot_lo_in;
      end
      if (stage2_ff) begin
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

FILE: rtl/string_hash_bucket_histogram.sv
// Top level: key hashing, per-bucket counter memory and report walk.
//
// Key bytes arrive on req_ with opcode in req_tuser and the final byte marked by req_tlast;
// each byte is folded into hash = hash*31 + byte. The final byte of a key starts the
// modulo unit (capture, reciprocal multiply, remainder), then the bucket's counters are read
// from memory, written back and the answer loaded; req_tready stays low until the answer is
// loaded. A report command walks the counter memory bucket by bucket (read, multiply by
// count+1 and halve, accumulate), and req_tready stays low until the last row is loaded.
// Both the key update and each report row wait while rsp_tready holds the output
// register. The counter memory needs no clearing pass: a per-bucket valid bit cleared by
// reset makes an untouched bucket read as zero.
module string_hash_bucket_histogram
   import shbh_pkg::*;
#(
   parameter int BUCKETS    = BUCKETS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int RSP_FIELD_BITS = BUCKET_BITS + 5*COUNT_BITS + 1 + COST_BITS,
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // key_byte
   input  logic [1:0]               req_tuser,   // opcode
   input  logic                     req_tlast,   // key_end
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // bucket, insert_count, live_count, all_inserts, max_inserts, min_inserts,
   // comparison_cost, zero pad
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,   // is_report
   output logic                     rsp_tlast    // last_row
);

   localparam int AW     = $clog2(BUCKETS);
   localparam int CB     = COUNT_BITS;
   localparam int PW     = 2*CB;
   localparam int TERM_W = PW - 1;
   localparam int SUM_W  = ((COST_BITS > TERM_W) ? COST_BITS : TERM_W) + 1;

   localparam int OFF_INS   = BUCKET_BITS;
   localparam int OFF_LIVE  = OFF_INS + CB;
   localparam int OFF_TOTAL = OFF_LIVE + CB + 1;
   localparam int OFF_MAX   = OFF_TOTAL + CB;
   localparam int OFF_MIN   = OFF_MAX + CB;
   localparam int OFF_COST  = OFF_MIN + CB;

   localparam logic [CB-1:0]        CNT_MAX  = '1;
   localparam logic signed [CB:0]   LIVE_MAX = {1'b0, {CB{1'b1}}};
   localparam logic signed [CB:0]   LIVE_MIN = {1'b1, {CB{1'b0}}};
   localparam logic [COST_BITS-1:0] COST_MAX = '1;
   localparam logic [AW-1:0]        LAST_ROW = AW'(BUCKETS-1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MODW  = 3'd1;
   localparam logic [2:0] S_KUPD  = 3'd2;
   localparam logic [2:0] S_RRD   = 3'd3;
   localparam logic [2:0] S_RMUL  = 3'd4;
   localparam logic [2:0] S_REMIT = 3'd5;

   typedef struct packed {
      logic [CB-1:0]      ins;
      logic signed [CB:0] live;
   } entry_type;

   // counter memory, one entry per bucket
   entry_type       mem [BUCKETS];
   entry_type       rd_data_ff;
   logic            rd_valid_ff;
   logic [BUCKETS-1:0] valid_ff;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            mem_we;
   entry_type       wr_entry;
   entry_type       cur_entry;

   logic [2:0]           state_ff, state_in;
   logic [HASH_BITS-1:0] hash_ff, hash_in, hash_next;
   logic [1:0]           op_ff, op_in;
   logic [AW-1:0]        bucket_ff, bucket_in;
   logic [AW-1:0]        row_ff, row_in;
   logic [CB-1:0]        total_ff, total_in;
   logic [CB-1:0]        max_ff, max_in;
   logic [CB-1:0]        min_ff, min_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic [TERM_W-1:0]    term_ff, term_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_report_ff, out_report_in;
   logic [BUCKET_BITS-1:0] out_bucket_ff, out_bucket_in;
   logic [CB-1:0]          out_ins_ff, out_ins_in;
   logic [CB:0]            out_live_ff, out_live_in;
   logic [CB-1:0]          out_total_ff, out_total_in;
   logic [CB-1:0]          out_max_ff, out_max_in;
   logic [CB-1:0]          out_min_ff, out_min_in;
   logic [COST_BITS-1:0]   out_cost_ff, out_cost_in;
   logic                   out_last_ff, out_last_in;

   logic                 accept;
   logic                 out_free;
   logic                 mod_start;
   logic                 mod_done;
   logic [AW-1:0]        mod_rem;
   logic [CB-1:0]        ins_new;
   logic signed [CB:0]   live_new;
   logic [CB-1:0]        total_new;
   logic [PW-1:0]        prod;
   logic [SUM_W-1:0]     cost_sum;
   logic [COST_BITS-1:0] cost_sat;
   logic [CB-1:0]        max_row, min_row;

   shbh_mod_unit #(
      .BUCKETS (BUCKETS)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .key_hash (hash_next),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign hash_next  = HASH_BITS'(hash_ff * HASH_BITS'(HASH_MULT)) + HASH_BITS'(req_tdata);
   assign cur_entry  = rd_valid_ff ? rd_data_ff : '0;

   // read-modify-write of one bucket for a finished key
   always_comb begin
      ins_new   = cur_entry.ins;
      live_new  = cur_entry.live;
      total_new = total_ff;
      if (op_ff == OP_INSERT) begin
         if (cur_entry.ins != CNT_MAX) begin
            ins_new = cur_entry.ins + 1'b1;
         end
         if (cur_entry.live != LIVE_MAX) begin
            live_new = cur_entry.live + 1'b1;
         end
         if (total_ff != CNT_MAX) begin
            total_new = total_ff + 1'b1;
         end
      end else if (op_ff == OP_DELETE) begin
         if (cur_entry.live != LIVE_MIN) begin
            live_new = cur_entry.live - 1'b1;
         end
      end
   end

   assign mem_we        = (state_ff == S_KUPD) && out_free && (op_ff != OP_FIND);
   assign wr_entry.ins  = ins_new;
   assign wr_entry.live = live_new;

   assign rd_en   = ((state_ff == S_MODW) && mod_done) || (state_ff == S_RRD);
   assign rd_addr = (state_ff == S_RRD) ? row_ff : mod_rem;

   // report row arithmetic
   assign prod     = PW'(cur_entry.ins) * PW'({1'b0, cur_entry.ins} + 1'b1);
   assign cost_sum = SUM_W'(cost_ff) + SUM_W'(term_ff);
   assign cost_sat = (cost_sum > SUM_W'(COST_MAX)) ? COST_MAX : cost_sum[COST_BITS-1:0];
   assign max_row  = (cur_entry.ins > max_ff) ? cur_entry.ins : max_ff;
   assign min_row  = ((row_ff == '0) || (cur_entry.ins < min_ff)) ? cur_entry.ins : min_ff;

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      op_in         = op_ff;
      bucket_in     = bucket_ff;
      row_in        = row_ff;
      total_in      = total_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      cost_in       = cost_ff;
      term_in       = term_ff;
      mod_start     = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_report_in = out_report_ff;
      out_bucket_in = out_bucket_ff;
      out_ins_in    = out_ins_ff;
      out_live_in   = out_live_ff;
      out_total_in  = out_total_ff;
      out_max_in    = out_max_ff;
      out_min_in    = out_min_ff;
      out_cost_in   = out_cost_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == OP_REPORT) begin
                  row_in   = '0;
                  max_in   = '0;
                  cost_in  = '0;
                  state_in = S_RRD;
               end else if (req_tlast) begin
                  op_in     = req_tuser;
                  hash_in   = '0;
                  mod_start = 1'b1;
                  state_in  = S_MODW;
               end else begin
                  hash_in = hash_next;
               end
            end
         end
         S_MODW: begin
            if (mod_done) begin
               bucket_in = mod_rem;
               state_in  = S_KUPD;
            end
         end
         S_KUPD: begin
            if (out_free) begin
               total_in      = total_new;
               out_valid_in  = 1'b1;
               out_report_in = 1'b0;
               out_bucket_in = BUCKET_BITS'(bucket_ff);
               out_ins_in    = ins_new;
               out_live_in   = live_new;
               out_total_in  = total_new;
               out_max_in    = '0;
               out_min_in    = '0;
               out_cost_in   = '0;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RRD: begin
            state_in = S_RMUL;
         end
         S_RMUL: begin
            term_in  = prod[PW-1:1];
            state_in = S_REMIT;
         end
         S_REMIT: begin
            if (out_free) begin
               max_in        = max_row;
               min_in        = min_row;
               cost_in       = cost_sat;
               out_valid_in  = 1'b1;
               out_report_in = 1'b1;
               out_bucket_in = BUCKET_BITS'(row_ff);
               out_ins_in    = cur_entry.ins;
               out_live_in   = cur_entry.live;
               out_total_in  = total_ff;
               out_max_in    = max_row;
               out_min_in    = min_row;
               out_cost_in   = cost_sat;
               out_last_in   = (row_ff == LAST_ROW);
               if (row_ff == LAST_ROW) begin
                  state_in = S_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = S_RRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hash_ff      <= '0;
         total_ff     <= '0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
         if (mem_we) begin
            valid_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bucket_ff     <= bucket_in;
      row_ff        <= row_in;
      max_ff        <= max_in;
      min_ff        <= min_in;
      cost_ff       <= cost_in;
      term_ff       <= term_in;
      out_report_ff <= out_report_in;
      out_bucket_ff <= out_bucket_in;
      out_ins_ff    <= out_ins_in;
      out_live_ff   <= out_live_in;
      out_total_ff  <= out_total_in;
      out_max_ff    <= out_max_in;
      out_min_ff    <= out_min_in;
      out_cost_ff   <= out_cost_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[bucket_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      rsp_tdata                          = '0;
      rsp_tdata[BUCKET_BITS-1:0]         = out_bucket_ff;
      rsp_tdata[OFF_INS +: CB]           = out_ins_ff;
      rsp_tdata[OFF_LIVE +: CB+1]        = out_live_ff;
      rsp_tdata[OFF_TOTAL +: CB]         = out_total_ff;
      rsp_tdata[OFF_MAX +: CB]           = out_max_ff;
      rsp_tdata[OFF_MIN +: CB]           = out_min_ff;
      rsp_tdata[OFF_COST +: COST_BITS]   = out_cost_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_report_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
